[src/ats_pkg.sv]
package ats_pkg;

   localparam int unsigned FIELD_WIDTH = 16;
   localparam int unsigned PACK_WIDTH  = 64;
   localparam int unsigned INDEX_WIDTH = 2;

   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_INIT = 2'd1,
      MODE_ON   = 2'd2
   } mode_type;

   typedef enum logic [1:0] {
      CSR_SEG_FREQ  = 2'd0,
      CSR_SEG_DUR   = 2'd1,
      CSR_BACKOFF   = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [PACK_WIDTH-1:0]  seg_freq;
      logic [PACK_WIDTH-1:0]  seg_dur;
      logic [FIELD_WIDTH-1:0] backoff_limit;
   } cfg_type;

   typedef struct packed {
      mode_type               mode;
      logic [INDEX_WIDTH-1:0] seg_index;
      logic [FIELD_WIDTH-1:0] seg_ticks;
      logic [1:0]             seg_res;
      logic [FIELD_WIDTH-1:0] quiet;
      logic [FIELD_WIDTH-1:0] freq;
      logic                   pwm;
      logic                   led;
   } state_type;

   typedef struct packed {
      logic                   pwm_enable;
      logic [FIELD_WIDTH-1:0] tone_frequency;
      logic                   leds_lit;
      logic [1:0]             alarm_mode;
   } rsp_type;

endpackage

[src/ats_step.sv]
module ats_step import ats_pkg::*; #(
   parameter int unsigned SEGMENTS = 4
) (
   input  state_type cur,
   input  cfg_type   cfg,
   input  logic      should_alarm,
   output state_type nxt
);

   localparam logic [INDEX_WIDTH:0] LAST_SEG = (INDEX_WIDTH+1)'(SEGMENTS - 1);

   logic [FIELD_WIDTH-1:0] quiet_inc;
   logic                   backoff_hit;
   mode_type               mode_mid;
   mode_type               mode_nxt;
   logic [INDEX_WIDTH:0]   index_inc;
   logic [INDEX_WIDTH-1:0] index_wrap;
   logic [FIELD_WIDTH-1:0] seg_dur;
   logic                   seg_end;

   // backoff step: saturating quiet count
   assign quiet_inc   = (cur.quiet == '1) ? cur.quiet : cur.quiet + 1'b1;
   assign backoff_hit = !should_alarm && (quiet_inc >= cfg.backoff_limit);
   assign mode_mid    = backoff_hit ? MODE_OFF : cur.mode;

   assign index_inc  = {1'b0, cur.seg_index} + 1'b1;
   assign index_wrap = (index_inc > LAST_SEG) ? '0 : index_inc[INDEX_WIDTH-1:0];
   assign seg_dur    = cfg.seg_dur[cur.seg_index*FIELD_WIDTH +: FIELD_WIDTH];
   assign seg_end    = cur.seg_ticks >= seg_dur;

   // next mode
   always_comb begin
      mode_nxt = mode_mid;
      case (mode_mid)
         MODE_OFF: begin
            if (should_alarm) mode_nxt = MODE_INIT;
         end
         MODE_INIT: mode_nxt = MODE_ON;
         MODE_ON:   mode_nxt = MODE_ON;
         default:   mode_nxt = mode_mid;
      endcase
   end

   // datapath
   always_comb begin
      nxt.mode      = mode_nxt;
      nxt.seg_index = cur.seg_index;
      nxt.seg_ticks = cur.seg_ticks;
      nxt.seg_res   = cur.seg_res;
      nxt.freq      = cur.freq;
      nxt.quiet     = should_alarm ? '0 : quiet_inc;
      nxt.pwm       = backoff_hit ? 1'b0 : cur.pwm;
      if (should_alarm) begin
         nxt.led = cur.led;
      end else begin
         nxt.led = backoff_hit ? 1'b0 : !cur.led;
      end
      case (mode_mid)
         MODE_INIT: begin
            nxt.quiet     = '0;
            nxt.seg_index = '0;
            nxt.freq      = '0;
            nxt.pwm       = 1'b1;
            nxt.seg_ticks = FIELD_WIDTH'(1);
            nxt.seg_res   = 2'd1;
         end
         MODE_ON: begin
            // seg_res tracks seg_ticks mod 3
            if (cur.seg_res == 2'd0) nxt.led = !nxt.led;
            if (seg_end) begin
               nxt.seg_index = index_wrap;
               nxt.freq      = cfg.seg_freq[index_wrap*FIELD_WIDTH +: FIELD_WIDTH];
               nxt.seg_ticks = '0;
               nxt.seg_res   = 2'd0;
            end else begin
               // no overflow: a full count always ends the segment
               nxt.seg_ticks = cur.seg_ticks + 1'b1;
               nxt.seg_res   = (cur.seg_res == 2'd2) ? 2'd0 : cur.seg_res + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

[src/alarm_tone_sequencer.sv]
// Alarm tone sequencer: one transaction on req_ is one timer tick and gives exactly one
// transaction on rsp_ with the PWM enable, commanded tone frequency, LED level and the mode
// after that tick. A tick is taken every clock cycle while req_stall is low: the whole update is
// one pass of logic between the state registers and the result register, and the result is
// registered in the output register, or in the skid stage while that one still holds a result.
// The one-entry skid stage lets a new tick in while a result waits; req_stall rises only once
// both hold a result. Write the csr_ registers only while no transaction is in flight.
module alarm_tone_sequencer import ats_pkg::*; #(
   parameter int unsigned SEGMENTS = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write,
   input  logic [1:0]             csr_index,
   input  logic [PACK_WIDTH-1:0]  csr_wdata,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_should_alarm,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_pwm_enable,
   output logic [FIELD_WIDTH-1:0] rsp_tone_frequency,
   output logic                   rsp_leds_lit,
   output logic [1:0]             rsp_alarm_mode
);

   cfg_type   cfg_ff, cfg_in;
   state_type state_ff, state_in;
   state_type step_nxt;
   rsp_type   step_rsp;
   rsp_type   out_ff, out_in;
   rsp_type   skid_ff, skid_in;
   logic      out_valid_ff, out_valid_in;
   logic      skid_valid_ff, skid_valid_in;
   logic      req_take;
   logic      out_take;

   ats_step #(.SEGMENTS(SEGMENTS)) u_step (
      .cur          (state_ff),
      .cfg          (cfg_ff),
      .should_alarm (req_should_alarm),
      .nxt          (step_nxt)
   );

   assign req_stall = skid_valid_ff;
   assign req_take  = req_valid && !skid_valid_ff;
   assign out_take  = out_valid_ff && !rsp_stall;

   assign step_rsp.pwm_enable     = step_nxt.pwm;
   assign step_rsp.tone_frequency = step_nxt.freq;
   assign step_rsp.leds_lit       = step_nxt.led;
   assign step_rsp.alarm_mode     = step_nxt.mode;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SEG_FREQ: cfg_in.seg_freq      = csr_wdata;
            CSR_SEG_DUR:  cfg_in.seg_dur       = csr_wdata;
            CSR_BACKOFF:  cfg_in.backoff_limit = csr_wdata[FIELD_WIDTH-1:0];
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   assign state_in = req_take ? step_nxt : state_ff;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (req_take) begin
         if (!out_valid_ff || out_take) begin
            out_in       = step_rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = step_rsp;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.seg_freq      <= '0;
         cfg_ff.seg_dur       <= '0;
         cfg_ff.backoff_limit <= FIELD_WIDTH'(10);
         state_ff             <= '{mode: MODE_OFF, default: '0};
         out_valid_ff         <= 1'b0;
         skid_valid_ff        <= 1'b0;
      end else begin
         cfg_ff        <= cfg_in;
         state_ff      <= state_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_pwm_enable     = out_ff.pwm_enable;
   assign rsp_tone_frequency = out_ff.tone_frequency;
   assign rsp_leds_lit       = out_ff.leds_lit;
   assign rsp_alarm_mode     = out_ff.alarm_mode;

`ifndef SYNTHESIS
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid stage holds a result with the output register empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> !skid_valid_ff)
      else $error("skid stage did not drain after the output was taken");

   a_pwm_follows_mode: assert property (@(posedge clock) disable iff (reset)
      state_ff.pwm == (state_ff.mode == MODE_ON))
      else $error("PWM enable out of step with mode");

   a_residue_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.seg_res != 2'd3)
      else $error("segment tick residue out of range");

   a_alarm_clears_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_should_alarm) |=> (state_ff.quiet == '0))
      else $error("alarm tick left the quiet count set");
`endif

endmodule
